>>> hdl/dlt_pkg.sv
// shared types and codes for the display list table
// no dependencies; imported by dlt_scan and display_list_table
`default_nettype none

package dlt_pkg;

    localparam int DEFAULT_LIST_DEPTH = 1024;

    // field widths
    localparam int TYPE_W   = 8;
    localparam int DBI_W    = 32;
    localparam int EIDX_W   = 10;
    localparam int STATUS_W = 3;

    // stream widths
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    // operation codes
    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_MODE   = 2'd1;
    localparam logic [1:0] FN_LOOKUP = 2'd2;
    localparam logic [1:0] FN_NONE   = 2'd3;

    // display mode codes
    localparam logic [1:0] MD_SHOW   = 2'd0;
    localparam logic [1:0] MD_HIDE   = 2'd1;
    localparam logic [1:0] MD_TOGGLE = 2'd2;
    localparam logic [1:0] MD_KEEP   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL_NOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

    // search key of one record
    typedef struct packed {
        logic [TYPE_W-1:0] obj_type;
        logic [DBI_W-1:0]  db_index;
    } t_key;

    // search status from the scan engine
    typedef struct packed {
        logic done;
        logic found;
    } t_scan_res;

endpackage

`default_nettype wire

>>> hdl/dlt_scan.sv
// key memory of the display list table and its newest-first search engine
// depends on dlt_pkg
`default_nettype none

module dlt_scan
    import dlt_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(LIST_DEPTH)-1:0] i_wr_addr,
    input  wire t_key                          i_wr_key,
    input  wire logic                          i_start,
    input  wire logic [$clog2(LIST_DEPTH):0]   i_count,
    input  wire t_key                          i_key,
    output t_scan_res                          o_res,
    output logic [$clog2(LIST_DEPTH)-1:0]      o_idx
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = AW + 1;

    t_key            r_key_mem [LIST_DEPTH];
    t_key            r_rd_key;
    t_key            r_key;
    logic            r_busy;
    logic [CW-1:0]   r_left;
    logic            r_rd_valid;
    logic [AW-1:0]   r_rd_idx;
    t_scan_res       r_res;
    logic [AW-1:0]   r_idx;

    logic            w_rd_en;
    logic [CW-1:0]   w_left_m1;
    logic [AW-1:0]   w_rd_addr;
    logic            w_match;
    logic            w_finish;

    always_comb begin
        w_rd_en   = r_busy && (r_left != '0);
        w_left_m1 = r_left - CW'(1);
        w_rd_addr = w_left_m1[AW-1:0];
        w_match   = r_rd_valid && (r_rd_key == r_key);
        // stop on a hit, or once every issued read has been compared
        w_finish  = r_busy && (w_match || (!r_rd_valid && (r_left == '0)));
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        if (w_rd_en) begin
            r_rd_key <= r_key_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_left     <= '0;
            r_rd_valid <= 1'b0;
            r_res      <= '0;
        end else begin
            r_res.done  <= w_finish;
            r_res.found <= w_match;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_left     <= i_count;
                r_rd_valid <= 1'b0;
            end else if (w_finish) begin
                r_busy     <= 1'b0;
                r_rd_valid <= 1'b0;
            end else if (r_busy) begin
                r_rd_valid <= w_rd_en;
                if (w_rd_en) begin
                    r_left <= w_left_m1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (w_rd_en) begin
            r_rd_idx <= w_rd_addr;
        end
        r_idx <= r_rd_idx;
    end

    assign o_res = r_res;
    assign o_idx = r_idx;

endmodule

`default_nettype wire

>>> hdl/display_list_table.sv
// display_list_table: append-only table of display records
// depends on dlt_pkg and dlt_scan
//
// one input stream carries operations, one output stream carries one result per
// transaction. s_axis tuser selects add, set display mode or lookup; m_axis
// tuser returns the status. items are processed one at a time:
//   add, ignored code : result decided at acceptance
//   set display mode  : read of the flag memory, then write back
//   lookup            : the key memory is read one entry per cycle,
//                       newest first, stopping on a hit
// the input is ready again in the cycle after the result enters the output
// register, so a new transaction is taken while a result waits downstream.
// when the receiver stalls, the result holds in the output register and a
// following result waits in the block, which then takes no new input.
// reset empties the table (count to zero) and clears the output valid;
// the record memories need no clearing, entries are read only once written.
// buffer offset, attribute word and vertex count have no read path and are
// not kept.
`default_nettype none

module display_list_table
    import dlt_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // obj_type, db_index, buf_offset, attr_word, vertex_count, entry_index,
    // disp_mode, zero fill
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // func
    input  wire logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // result_index, hide_flag, zero fill
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,
    // status
    output logic [M_TUSER_W-1:0]      o_m_axis_tuser
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = AW + 1;
    localparam int EW = (CW > EIDX_W) ? CW : EIDX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MODE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    logic                r_hide_mem [LIST_DEPTH];
    logic                r_hide_rd;

    logic [1:0]          r_mode;
    logic [AW-1:0]       r_eidx;
    logic [EIDX_W-1:0]   r_eidx_raw;

    logic [STATUS_W-1:0] r_pend_status;
    logic [STATUS_W-1:0] n_pend_status;
    logic [EIDX_W-1:0]   r_pend_idx;
    logic [EIDX_W-1:0]   n_pend_idx;
    logic                r_pend_flag;
    logic                n_pend_flag;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [EIDX_W-1:0]   r_out_idx;
    logic                r_out_flag;

    logic [1:0]          w_func;
    t_key                w_key;
    logic [EIDX_W-1:0]   w_eidx;
    logic [1:0]          w_mode;
    logic [EW-1:0]       w_eidx_ext;
    logic [EW-1:0]       w_slot_ext;
    logic [EW-1:0]       w_scan_ext;
    logic                w_acc;
    logic                w_full;
    logic                w_out_free;
    logic                w_load_out;
    logic                w_hide_we;
    logic [AW-1:0]       w_hide_waddr;
    logic                w_hide_wdata;
    logic                w_new_flag;
    logic                w_key_we;
    logic                w_scan_start;
    t_scan_res           w_scan_res;
    logic [AW-1:0]       w_scan_idx;

    // field unpacking
    always_comb begin
        w_func         = i_s_axis_tuser;
        w_key.obj_type = i_s_axis_tdata[7:0];
        w_key.db_index = i_s_axis_tdata[39:8];
        w_eidx         = i_s_axis_tdata[121:112];
        w_mode         = i_s_axis_tdata[123:122];
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        w_acc        = i_s_axis_tvalid && o_s_axis_tready;
        w_full       = (r_count == CW'(LIST_DEPTH));
        w_out_free   = !r_out_valid || i_m_axis_tready;
        w_load_out   = (r_state == S_EMIT) && w_out_free;
        w_eidx_ext   = EW'(w_eidx);
        w_slot_ext   = EW'(r_count);
        w_scan_ext   = EW'(w_scan_idx);
        w_key_we     = w_acc && (w_func == FN_ADD) && !w_full;
        w_scan_start = w_acc && (w_func == FN_LOOKUP);
    end

    always_comb begin
        unique case (r_mode)
            MD_SHOW:   w_new_flag = 1'b0;
            MD_HIDE:   w_new_flag = 1'b1;
            MD_TOGGLE: w_new_flag = ~r_hide_rd;
            default:   w_new_flag = r_hide_rd;
        endcase
    end

    // one write port on the flag memory: add clears, mode writes back
    always_comb begin
        w_hide_we    = 1'b0;
        w_hide_waddr = r_eidx;
        w_hide_wdata = w_new_flag;
        if (w_key_we) begin
            w_hide_we    = 1'b1;
            w_hide_waddr = r_count[AW-1:0];
            w_hide_wdata = 1'b0;
        end else if (r_state == S_MODE) begin
            w_hide_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hide_we) begin
            r_hide_mem[w_hide_waddr] <= w_hide_wdata;
        end
        if (w_acc) begin
            r_hide_rd <= r_hide_mem[w_eidx_ext[AW-1:0]];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pend_status = r_pend_status;
        n_pend_idx    = r_pend_idx;
        n_pend_flag   = r_pend_flag;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state       = S_EMIT;
                    n_pend_status = ST_OK;
                    n_pend_idx    = '0;
                    n_pend_flag   = 1'b0;
                    unique case (w_func)
                        FN_ADD: begin
                            if (w_full) begin
                                n_pend_status = ST_REJECTED;
                            end else begin
                                n_count    = r_count + CW'(1);
                                n_pend_idx = w_slot_ext[EIDX_W-1:0];
                                if (r_count == CW'(LIST_DEPTH - 1)) begin
                                    n_pend_status = ST_FULL_NOW;
                                end
                            end
                        end
                        FN_MODE: begin
                            n_pend_idx = w_eidx;
                            if (w_eidx_ext >= EW'(r_count)) begin
                                n_pend_status = ST_BAD_INDEX;
                            end else begin
                                n_state = S_MODE;
                            end
                        end
                        FN_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_pend_status = ST_OK;
                        end
                    endcase
                end
            end
            S_MODE: begin
                n_pend_flag = w_new_flag;
                n_state     = S_EMIT;
            end
            S_SCAN: begin
                if (w_scan_res.done) begin
                    n_state = S_EMIT;
                    if (w_scan_res.found) begin
                        n_pend_idx = w_scan_ext[EIDX_W-1:0];
                    end else begin
                        n_pend_status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        r_pend_idx    <= n_pend_idx;
        r_pend_flag   <= n_pend_flag;
        if (w_acc) begin
            r_mode     <= w_mode;
            r_eidx     <= w_eidx_ext[AW-1:0];
            r_eidx_raw <= w_eidx;
        end
        if (w_load_out) begin
            r_out_status <= r_pend_status;
            r_out_idx    <= r_pend_idx;
            r_out_flag   <= r_pend_flag;
        end
    end

    dlt_scan #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_key_we),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_key  (w_key),
        .i_start   (w_scan_start),
        .i_count   (r_count),
        .i_key     (w_key),
        .o_res     (w_scan_res),
        .o_idx     (w_scan_idx)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - EIDX_W - 1)'(0), r_out_flag, r_out_idx};
    assign o_m_axis_tuser  = r_out_status;

`ifndef ASSERT_OFF

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("entry count beyond table depth");

    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_res.done |-> (r_state == S_SCAN))
        else $error("search finished outside a lookup");

    a_found_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_scan_res.done && w_scan_res.found) |-> (EW'(w_scan_idx) < EW'(r_count)))
        else $error("search hit on an unwritten entry");

    a_mode_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MODE) |-> (EW'(r_eidx_raw) < EW'(r_count)))
        else $error("flag update on an unwritten entry");

`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
// tb_top: self-checking bench for the display_list_table block
// depends on dlt_pkg and the display_list_table rtl; drives the operation stream
// and checks every result against the built-in table model or a fixed expectation

module tb_top;
    import dlt_pkg::*;

    localparam int DEPTH        = DEFAULT_LIST_DEPTH;
    localparam int RANDOM_ITEMS = 540;
    localparam int QUIET_LIMIT  = 8000;
    localparam int PRINT_LIMIT  = 60;

    typedef struct packed {
        logic [1:0]        func;
        logic [TYPE_W-1:0] obj_type;
        logic [DBI_W-1:0]  db_index;
        logic [23:0]       buf_offset;
        logic [31:0]       attr_word;
        logic [15:0]       vertex_count;
        logic [EIDX_W-1:0] entry_index;
        logic [1:0]        disp_mode;
    } t_op;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [EIDX_W-1:0]   index;
        logic                hide;
    } t_result;

    typedef struct {
        t_op     op;
        bit      fixed;
        t_result res;
    } t_row;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // model copy of the record table
    int                rec_count = 0;
    logic [TYPE_W-1:0] rec_type   [DEPTH];
    logic [DBI_W-1:0]  rec_dbi    [DEPTH];
    logic [23:0]       rec_offset [DEPTH];
    logic [31:0]       rec_attr   [DEPTH];
    logic [15:0]       rec_vcount [DEPTH];
    bit                rec_hide   [DEPTH];

    t_result awaited_results[$];
    t_row    directed_rows[$];

    int  errors     = 0;
    int  n_add      = 0;
    int  n_mode     = 0;
    int  n_lookup   = 0;
    int  n_ignored  = 0;
    int  n_rejected = 0;
    bit  tx_calm    = 1'b0;
    bit  rx_calm    = 1'b0;
    int  rx_stall   = 0;

    display_list_table #(.LIST_DEPTH(DEPTH)) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // applies one operation to the model table and returns its result
    function automatic t_result records_step(t_op op);
        t_result res;
        int      slot;
        bit      hit;
        res = '0;
        hit = 1'b0;
        case (op.func)
            FN_ADD: begin
                if (rec_count >= DEPTH) begin
                    res.status = ST_REJECTED;
                end else begin
                    slot = rec_count;
                    rec_type[slot]   = op.obj_type;
                    rec_dbi[slot]    = op.db_index;
                    rec_offset[slot] = op.buf_offset;
                    rec_attr[slot]   = op.attr_word;
                    rec_vcount[slot] = op.vertex_count;
                    rec_hide[slot]   = 1'b0;
                    rec_count++;
                    res.status = (rec_count >= DEPTH) ? ST_FULL_NOW : ST_OK;
                    res.index  = slot[EIDX_W-1:0];
                end
            end
            FN_MODE: begin
                res.index = op.entry_index;
                if (op.entry_index >= rec_count) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    case (op.disp_mode)
                        MD_SHOW:   rec_hide[op.entry_index] = 1'b0;
                        MD_HIDE:   rec_hide[op.entry_index] = 1'b1;
                        MD_TOGGLE: rec_hide[op.entry_index] = !rec_hide[op.entry_index];
                        default: ;
                    endcase
                    res.status = ST_OK;
                    res.hide   = rec_hide[op.entry_index];
                end
            end
            FN_LOOKUP: begin
                res.status = ST_NOT_FOUND;
                // newest entry wins
                for (int i = rec_count - 1; i >= 0 && !hit; i--) begin
                    if (rec_type[i] == op.obj_type && rec_dbi[i] == op.db_index) begin
                        hit        = 1'b1;
                        res.status = ST_OK;
                        res.index  = i[EIDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_op mk_op(logic [1:0] func, logic [TYPE_W-1:0] ty,
                                  logic [DBI_W-1:0] dbi, logic [EIDX_W-1:0] eidx,
                                  logic [1:0] mode);
        t_op op;
        op             = '0;
        op.func        = func;
        op.obj_type    = ty;
        op.db_index    = dbi;
        op.entry_index = eidx;
        op.disp_mode   = mode;
        return op;
    endfunction

    // weights in percent; what is left over goes to the ignored code
    function automatic t_op random_op(int add_w, int mode_w, int look_w);
        t_op op;
        int  roll;
        int  pick;
        op.obj_type     = TYPE_W'($urandom);
        op.db_index     = $urandom;
        op.buf_offset   = 24'($urandom);
        op.attr_word    = $urandom;
        op.vertex_count = 16'($urandom);
        op.entry_index  = EIDX_W'($urandom);
        op.disp_mode    = 2'($urandom);
        // small key pool so that lookups hit and duplicates appear
        if ($urandom_range(0, 9) < 7) op.obj_type = TYPE_W'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 6) op.db_index = DBI_W'(int'($urandom_range(0, 7)) - 4);
        roll = $urandom_range(0, 99);
        if (roll < add_w) begin
            op.func = FN_ADD;
        end else if (roll < add_w + mode_w) begin
            op.func = FN_MODE;
            if (rec_count > 0 && $urandom_range(0, 9) < 8)
                op.entry_index = EIDX_W'($urandom_range(0, rec_count - 1));
        end else if (roll < add_w + mode_w + look_w) begin
            op.func = FN_LOOKUP;
            if (rec_count > 0 && $urandom_range(0, 9) < 6) begin
                pick        = $urandom_range(0, rec_count - 1);
                op.obj_type = rec_type[pick];
                op.db_index = rec_dbi[pick];
            end
        end else begin
            op.func = FN_NONE;
        end
        return op;
    endfunction

    task automatic add_row(t_op op, bit fixed, logic [STATUS_W-1:0] st,
                           logic [EIDX_W-1:0] idx, logic hide);
        t_row row;
        row.op         = op;
        row.fixed      = fixed;
        row.res.status = st;
        row.res.index  = idx;
        row.res.hide   = hide;
        directed_rows.push_back(row);
    endtask

    // drives one operation, waits for its transaction and records what to expect
    task automatic push_request(t_op op, bit fixed, t_result fixed_res);
        t_result res;
        int      gap;
        gap = pick_gap(tx_calm);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, op.disp_mode, op.entry_index, op.vertex_count,
                     op.attr_word, op.buf_offset, op.db_index, op.obj_type};
        s_tuser  <= op.func;
        do @(posedge clk); while (!s_tready);
        res = records_step(op);
        if (fixed) res = fixed_res;
        awaited_results.push_back(res);
        case (op.func)
            FN_ADD:    n_add++;
            FN_MODE:   n_mode++;
            FN_LOOKUP: n_lookup++;
            default:   n_ignored++;
        endcase
        if (res.status == ST_REJECTED) n_rejected++;
    endtask

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // receiver: random stalls with calm stretches
    always @(negedge clk) begin
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall = pick_gap(rx_calm);
        end
    end

    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tuser[STATUS_W-1:0];
            got.index  = m_tdata[EIDX_W-1:0];
            got.hide   = m_tdata[EIDX_W];
            if (awaited_results.size() == 0) begin
                note_mismatch("unexpected result, status", 0, got.status);
            end else begin
                want = awaited_results.pop_front();
                if (got.status != want.status) note_mismatch("status", want.status, got.status);
                if (got.index != want.index) note_mismatch("result_index", want.index, got.index);
                if (got.hide != want.hide) note_mismatch("hide_flag", want.hide, got.hide);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        t_op op;
        int  done_items;
        int  k;

        // empty table corner cases
        add_row(mk_op(FN_LOOKUP, 8'h00, 32'h0, 10'd0, MD_SHOW), 1, ST_NOT_FOUND, 10'd0, 0);
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd0, MD_HIDE), 1, ST_BAD_INDEX, 10'd0, 0);
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd1023, MD_TOGGLE), 1, ST_BAD_INDEX, 10'd1023, 0);
        op = '1;
        add_row(op, 1, ST_OK, 10'd0, 0);
        // field extremes on add
        add_row(mk_op(FN_ADD, 8'h00, 32'h0, 10'd0, MD_SHOW), 1, ST_OK, 10'd0, 0);
        op = mk_op(FN_ADD, 8'hFF, 32'h7FFF_FFFF, 10'd1023, MD_KEEP);
        op.buf_offset   = '1;
        op.attr_word    = '1;
        op.vertex_count = '1;
        add_row(op, 1, ST_OK, 10'd1, 0);
        add_row(mk_op(FN_ADD, 8'h80, 32'h8000_0000, 10'd0, MD_SHOW), 1, ST_OK, 10'd2, 0);
        add_row(mk_op(FN_ADD, 8'hFF, 32'hFFFF_FFFF, 10'd0, MD_SHOW), 1, ST_OK, 10'd3, 0);
        add_row(mk_op(FN_ADD, 8'h00, 32'h0, 10'd0, MD_SHOW), 1, ST_OK, 10'd4, 0);
        // lookups: duplicate key returns the newest, partial matches miss
        add_row(mk_op(FN_LOOKUP, 8'h00, 32'h0, 10'd0, MD_SHOW), 1, ST_OK, 10'd4, 0);
        add_row(mk_op(FN_LOOKUP, 8'hFF, 32'h7FFF_FFFF, 10'd0, MD_SHOW), 1, ST_OK, 10'd1, 0);
        add_row(mk_op(FN_LOOKUP, 8'h80, 32'h8000_0000, 10'd0, MD_SHOW), 1, ST_OK, 10'd2, 0);
        add_row(mk_op(FN_LOOKUP, 8'hFF, 32'h8000_0000, 10'd0, MD_SHOW), 1, ST_NOT_FOUND, 10'd0, 0);
        add_row(mk_op(FN_LOOKUP, 8'h80, 32'h7FFF_FFFF, 10'd0, MD_SHOW), 1, ST_NOT_FOUND, 10'd0, 0);
        // every display mode on one entry
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd1, MD_HIDE), 1, ST_OK, 10'd1, 1);
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd1, MD_KEEP), 1, ST_OK, 10'd1, 1);
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd1, MD_TOGGLE), 1, ST_OK, 10'd1, 0);
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd1, MD_TOGGLE), 1, ST_OK, 10'd1, 1);
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd1, MD_SHOW), 1, ST_OK, 10'd1, 0);
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd4, MD_KEEP), 1, ST_OK, 10'd4, 0);
        // first index past the written entries
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd5, MD_HIDE), 1, ST_BAD_INDEX, 10'd5, 0);
        add_row(mk_op(FN_MODE, 8'h00, 32'h0, 10'd4, MD_HIDE), 1, ST_OK, 10'd4, 1);
        // a hidden entry is still found, flag reads zero on lookup
        add_row(mk_op(FN_LOOKUP, 8'h00, 32'h0, 10'd0, MD_SHOW), 1, ST_OK, 10'd4, 0);
        op = mk_op(FN_ADD, 8'h01, 32'hFFFF_FFFB, 10'd0, MD_SHOW);
        op.buf_offset = 24'h5A5A5A;
        add_row(op, 0, ST_OK, 10'd0, 0);
        add_row(mk_op(FN_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 10'd0, MD_SHOW), 0, ST_OK, 10'd0, 0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            push_request(directed_rows[i].op, directed_rows[i].fixed, directed_rows[i].res);

        done_items = 0;
        k = 0;
        while (done_items < RANDOM_ITEMS) begin
            if (k % 64 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            k++;
            op = random_op(45, 20, 25);
            push_request(op, 0, '0);
            done_items++;
        end

        // closing checks: more adds, newest entry, oldest-entry and missing-key scans
        repeat (3) push_request(random_op(100, 0, 0), 0, '0);
        push_request(mk_op(FN_MODE, 8'h00, 32'h0, EIDX_W'(rec_count - 1), MD_TOGGLE), 0, '0);
        push_request(mk_op(FN_MODE, 8'h00, 32'h0, 10'd0, MD_KEEP), 0, '0);
        op = random_op(0, 0, 100);
        op.obj_type = rec_type[0];
        op.db_index = rec_dbi[0];
        push_request(op, 0, '0);
        push_request(mk_op(FN_LOOKUP, 8'hA7, 32'h1234_5678, 10'd0, MD_SHOW), 0, '0);
        push_request(random_op(0, 0, 0), 0, '0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("covered %0d adds (%0d rejected), %0d display-mode updates, %0d lookups, %0d ignored codes",
                 n_add, n_rejected, n_mode, n_lookup, n_ignored);
        $display("table filled to %0d of %0d entries, %0d mismatches", rec_count, DEPTH, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
